@@ hw/rtl/dssm_pkg.sv @@
// Shared types and constants for the dual stack block.
// No dependencies; imported by every module of the block.
package dssm_pkg;

  localparam int DEPTH   = 16;
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 5;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CFG_RST = 16;

  typedef enum logic [1:0] {
    OP_PUSH_LO = 2'd0,
    OP_PUSH_HI = 2'd1,
    OP_POP_LO  = 2'd2,
    OP_POP_HI  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_ACCESS,
    CTL_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load_item;
    logic access;
    logic load_out;
  } dp_cmd_t;

  // Register values above the memory depth act as the full depth.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (int'(c) > DEPTH) r = CNT_W'(DEPTH);
    else r = CNT_W'(c);
    return r;
  endfunction

endpackage

@@ hw/rtl/dssm_ctrl.sv @@
// Sequencer for the dual stack block: accept, memory access, result load.
// Depends on dssm_pkg.
module dssm_ctrl
  import dssm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      CTL_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = CTL_ACCESS;
        end
      end
      CTL_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = CTL_FINISH;
      end
      CTL_FINISH: begin
        // output register free or draining this cycle
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ hw/rtl/dssm_datapath.sv @@
// Datapath: item registers, stack counters, slot memory, result register.
// Depends on dssm_pkg; driven by dssm_ctrl commands.
module dssm_datapath
  import dssm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [1:0]        in_mode,
  input  logic [WORD_W-1:0] in_value,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic [WORD_W-1:0] out_value,
  output logic [1:0]        out_status
);

  logic [WORD_W-1:0] mem [DEPTH];

  op_t               mode_r;
  logic [WORD_W-1:0] value_r;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cnt_lo_r, cnt_lo_nxt;
  logic [CNT_W-1:0]  cnt_hi_r, cnt_hi_nxt;
  logic [WORD_W-1:0] rd_data_r;
  status_t           res_status_r, res_status_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic [WORD_W-1:0] out_value_r;
  status_t           out_status_r;

  logic              wr_en, rd_en;
  logic [CNT_W-1:0]  slot;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W:0]    used;
  logic              room;

  assign used = {1'b0, cnt_lo_r} + {1'b0, cnt_hi_r};
  assign room = used < {1'b0, cap_r};
  assign addr = slot[ADDR_W-1:0];

  always_comb begin
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    slot           = '0;
    cnt_lo_nxt     = cnt_lo_r;
    cnt_hi_nxt     = cnt_hi_r;
    res_status_nxt = ST_DONE;
    pop_ok_nxt     = 1'b0;
    unique case (mode_r)
      OP_PUSH_LO: begin
        if (room) begin
          wr_en      = 1'b1;
          slot       = cnt_lo_r;
          cnt_lo_nxt = cnt_lo_r + 1'b1;
        end else begin
          res_status_nxt = ST_OVERFLOW;
        end
      end
      OP_PUSH_HI: begin
        if (room) begin
          wr_en      = 1'b1;
          slot       = cap_r - 1'b1 - cnt_hi_r;
          cnt_hi_nxt = cnt_hi_r + 1'b1;
        end else begin
          res_status_nxt = ST_OVERFLOW;
        end
      end
      OP_POP_LO: begin
        if (cnt_lo_r != '0) begin
          rd_en      = 1'b1;
          pop_ok_nxt = 1'b1;
          slot       = cnt_lo_r - 1'b1;
          cnt_lo_nxt = cnt_lo_r - 1'b1;
        end else begin
          res_status_nxt = ST_UNDERFLOW;
        end
      end
      OP_POP_HI: begin
        if (cnt_hi_r != '0 && cnt_hi_r <= cap_r) begin
          rd_en      = 1'b1;
          pop_ok_nxt = 1'b1;
          slot       = cap_r - cnt_hi_r;
          cnt_hi_nxt = cnt_hi_r - 1'b1;
        end else begin
          res_status_nxt = ST_UNDERFLOW;
        end
      end
      default: res_status_nxt = ST_DONE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= eff_cap(CFG_W'(CFG_RST));
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
    end else if (cfg_we) begin
      cap_r    <= eff_cap(cfg_data);
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
    end else if (cmd.access) begin
      cnt_lo_r <= cnt_lo_nxt;
      cnt_hi_r <= cnt_hi_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= op_t'(in_mode);
      value_r <= in_value;
    end
    if (cmd.access) begin
      res_status_r <= res_status_nxt;
      pop_ok_r     <= pop_ok_nxt;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      if (pop_ok_r) out_value_r <= rd_data_r;
      else if (res_status_r == ST_UNDERFLOW) out_value_r <= '1;
      else out_value_r <= '0;
    end
  end

  // slot memory, one access per item
  always_ff @(posedge clk) begin
    if (cmd.access && wr_en) mem[addr] <= value_r;
    if (cmd.access && rd_en) rd_data_r <= mem[addr];
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

@@ hw/rtl/dual_stack_shared_memory.sv @@
// Top level of the dual stack block: two LIFO stacks in one slot memory.
// Depends on dssm_pkg, dssm_ctrl and dssm_datapath.
//
//   channel | direction | tdata            | tuser
//   --------+-----------+------------------+--------------------------
//   in_     | sink      | [31:0] push_value| [1:0] mode
//   out_    | source    | [31:0] pop_value | [1:0] status
//   cfg_    | sink      | cfg_data [4:0] capacity_in_use, on cfg_we
//
// Each item passes the input register load at the transfer, then the
// single-port slot memory access, then the output register load; a new
// item is taken only after the previous one is in the output register.
// The next item is taken while the previous result still waits for
// out_tready; the sequencer stalls in its last step only if that result
// has not left yet. Reset (rst_n low, synchronous) empties both stacks and
// sets the capacity to 16; memory contents are not cleared. A write to the
// capacity register also empties both stacks.
module dual_stack_shared_memory
  import dssm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]        in_tuser,   // [1:0] mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,  // [31:0] pop_value
  output logic [1:0]        out_tuser,  // [1:0] status
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data
);

  dp_cmd_t cmd;

  // sequencer: decides when an item is taken and when the result loads
  dssm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // stack counters, slot memory and result register
  dssm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_tuser),
    .in_value   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

@@ hw/rtl/dssm_checker.sv @@
// Port-level checks for the dual stack block, bound to the top level.
// Depends on dssm_pkg.
module dssm_checker
  import dssm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [WORD_W-1:0] out_tdata,
  input logic [1:0]        out_tuser
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  // one item in flight: not ready right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a result cannot appear sooner than the access latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 !(out_tvalid && !$past(out_tvalid)) || $past(out_tvalid, 1))
    else $error("result came too early");

  a_underflow_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_UNDERFLOW |-> out_tdata == '1)
    else $error("underflow result is not all ones");

  a_overflow_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OVERFLOW |-> out_tdata == '0)
    else $error("overflow result is not zero");

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
